### sv/ltr_pkg.sv
// Package for the linear trace resampler: payload structs, register indexes,
// item kind codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ltr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW     = 13;

  localparam logic [CfgIdxW-1:0] CFG_START   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAD_VAL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAD_EN  = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [11:0]        sample_index;
    logic signed [31:0] sample_value;
  } ltr_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [31:0] running_min;
    logic signed [31:0] running_max;
  } ltr_out_t;

  typedef struct packed {
    logic load_wr;   // store write of the accepted load
    logic capture;   // latch output index of the accepted query
    logic mul;       // index times step
    logic pos;       // add start, saturate
    logic cls;       // classify position, read first sample
    logic latch_s0;  // hold first sample, read second
    logic diff;      // s1 - s0
    logic muli;      // fraction times difference
    logic finish;    // form result, update min/max
  } ltr_cmd_t;

  typedef struct packed {
    logic mid;       // position lies in the span, before its last sample
  } ltr_stat_t;

endpackage

`default_nettype wire

### sv/linear_trace_resampler_unit.sv
// Top level of the linear trace resampler: configuration registers,
// ltr_ctrl and ltr_datapath. Depends on ltr_pkg.
//
//  port group        dir  timing
//  start/busy/item_i in   transfer when start && !busy
//  result_valid_o    out  one-cycle strobe, result_o valid with it
//  cfg_we_i/idx/data in   register write on each edge with cfg_we_i
//
// A load is written to the trace store at its transfer edge; busy stays low.
// A query keeps busy high in MUL, POS, CLS, RD0, FIN, inside the span also
// in RD1, MULI (two reads of the single store port, then the multiply); the
// strobe follows in the next cycle, when a new item may already transfer.
// rst_ni clears config, min/max and control; the store is not cleared.
// No back-pressure on results.
`default_nettype none

module linear_trace_resampler_unit import ltr_pkg::*; #(
  parameter int unsigned TRACE_DEPTH = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire ltr_in_t             item_i,
  output logic                     result_valid_o,
  output ltr_out_t                 result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic signed [31:0] start_pos_q, step_pos_q, pad_value_q;
  logic [LenW-1:0]    length_q;
  logic               pad_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
      step_pos_q  <= 32'sd65536;
      length_q    <= LenW'(1);
      pad_value_q <= '0;
      pad_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:   start_pos_q <= cfg_data_i;
        CFG_STEP:    step_pos_q  <= cfg_data_i;
        CFG_LENGTH:  length_q    <= cfg_data_i[LenW-1:0];
        CFG_PAD_VAL: pad_value_q <= cfg_data_i;
        CFG_PAD_EN:  pad_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ltr_cmd_t  cmd;
  ltr_stat_t stat;

  ltr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (result_valid_o)
  );

  ltr_datapath #(
    .TRACE_DEPTH(TRACE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (item_i),
    .start_pos_i(start_pos_q),
    .step_pos_i (step_pos_q),
    .length_i   (length_q),
    .pad_value_i(pad_value_q),
    .pad_en_i   (pad_en_q),
    .stat_o     (stat),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

### sv/ltr_ctrl.sv
// Controller state machine of the linear trace resampler.
// Depends on ltr_pkg; drives commands to ltr_datapath.
`default_nettype none

module ltr_ctrl import ltr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      kind_i,
  input  wire ltr_stat_t stat_i,
  output ltr_cmd_t       cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_POS, S_CLS, S_RD0, S_RD1, S_MULI, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   done_q;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && kind_i == KIND_QUERY) state_d = S_MUL;
      S_MUL:  state_d = S_POS;
      S_POS:  state_d = S_CLS;
      S_CLS:  state_d = S_RD0;
      S_RD0:  state_d = stat_i.mid ? S_RD1 : S_FIN;
      S_RD1:  state_d = S_MULI;
      S_MULI: state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN);
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_wr  = accept && kind_i == KIND_LOAD;
    cmd_o.capture  = accept && kind_i == KIND_QUERY;
    cmd_o.mul      = state_q == S_MUL;
    cmd_o.pos      = state_q == S_POS;
    cmd_o.cls      = state_q == S_CLS;
    cmd_o.latch_s0 = state_q == S_RD0;
    cmd_o.diff     = state_q == S_RD1;
    cmd_o.muli     = state_q == S_MULI;
    cmd_o.finish   = state_q == S_FIN;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_LOAD) |=> (state_q == S_IDLE && !done_q))
    else $error("load caused work or a result");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_QUERY) |=> state_q == S_MUL)
    else $error("query not started");

endmodule

`default_nettype wire

### sv/ltr_datapath.sv
// Datapath of the linear trace resampler: trace store, position arithmetic,
// interpolation and running min/max. Depends on ltr_pkg; driven by ltr_ctrl.
`default_nettype none

module ltr_datapath import ltr_pkg::*; #(
  parameter int unsigned TRACE_DEPTH = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ltr_cmd_t           cmd_i,
  input  wire ltr_in_t            item_i,
  input  wire logic signed [31:0] start_pos_i,
  input  wire logic signed [31:0] step_pos_i,
  input  wire logic [LenW-1:0]    length_i,
  input  wire logic signed [31:0] pad_value_i,
  input  wire logic               pad_en_i,
  output ltr_stat_t               stat_o,
  output ltr_out_t                result_o
);

  localparam int unsigned AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(TRACE_DEPTH + 1);

  logic signed [31:0] mem [TRACE_DEPTH];
  logic signed [31:0] rd_q;
  logic [AW-1:0]      rd_addr;

  logic [11:0]        idx_q;
  logic signed [44:0] prod_q;
  logic signed [31:0] pos_q;
  logic [15:0]        frac_q;
  logic [AW-1:0]      ip_q;
  logic               edge_q, pad_sel_q;
  logic signed [31:0] s0_q;
  logic signed [32:0] diff_q;
  logic signed [49:0] prodi_q;

  logic signed [31:0] res, min_q, max_q, out_q;
  logic               have_q;

  // effective length and last index
  logic [LW-1:0] eff_len, lenm1;
  always_comb begin
    if (length_i == '0) begin
      eff_len = LW'(1);
    end else if (32'(length_i) > TRACE_DEPTH) begin
      eff_len = LW'(TRACE_DEPTH);
    end else begin
      eff_len = LW'(length_i);
    end
    lenm1 = eff_len - LW'(1);
  end

  // position classification
  logic        neg, high, pad_hi;
  logic [16:0] ipu, lenm1_x;
  assign neg     = pos_q[31];
  assign ipu     = {1'b0, pos_q[31:16]};
  assign lenm1_x = 17'(lenm1);
  assign high    = !neg && (ipu >= lenm1_x);
  assign pad_hi  = (ipu > lenm1_x) || (ipu == lenm1_x && pos_q[15:0] != '0);

  always_comb begin
    if (cmd_i.latch_s0) begin
      rd_addr = AW'(ip_q + AW'(1));
    end else if (neg) begin
      rd_addr = '0;
    end else if (high) begin
      rd_addr = AW'(lenm1);
    end else begin
      rd_addr = AW'(pos_q[31:16]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && 32'(item_i.sample_index) < TRACE_DEPTH) begin
      mem[AW'(item_i.sample_index)] <= item_i.sample_value;
    end
    rd_q <= mem[rd_addr];
  end

  // position sum, saturated
  logic signed [45:0] sum;
  logic signed [31:0] sat;
  always_comb begin
    sum = 46'(start_pos_i) + 46'(prod_q);
    if (sum[45:31] != {15{sum[45]}}) begin
      sat = sum[45] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    if (edge_q) begin
      res = pad_sel_q ? pad_value_i : s0_q;
    end else begin
      res = s0_q + prodi_q[47:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture)  idx_q   <= item_i.sample_index;
    if (cmd_i.mul)      prod_q  <= $signed({1'b0, idx_q}) * step_pos_i;
    if (cmd_i.pos)      pos_q   <= sat;
    if (cmd_i.cls) begin
      frac_q    <= pos_q[15:0];
      ip_q      <= AW'(pos_q[31:16]);
      edge_q    <= neg || high;
      pad_sel_q <= pad_en_i && (neg || (high && pad_hi));
    end
    if (cmd_i.latch_s0) s0_q    <= rd_q;
    if (cmd_i.diff)     diff_q  <= 33'(rd_q) - 33'(s0_q);
    if (cmd_i.muli)     prodi_q <= $signed({1'b0, frac_q}) * diff_q;
    if (cmd_i.finish)   out_q   <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      min_q  <= '0;
      max_q  <= '0;
    end else if (cmd_i.finish) begin
      have_q <= 1'b1;
      if (!have_q || res < min_q) min_q <= res;
      if (!have_q || res > max_q) max_q <= res;
    end
  end

  assign result_o    = {out_q, min_q, max_q};
  assign stat_o.mid  = !edge_q;

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= max_q)
    else $error("running min above running max");

  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (result_o.out_value >= min_q && result_o.out_value <= max_q))
    else $error("result outside running range");

  a_first_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !have_q) |=> (min_q == max_q))
    else $error("first result did not seed min and max");

endmodule

`default_nettype wire

### test/tb_linear_trace_resampler_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for linear_trace_resampler_unit: directed and random
// loads and queries go through the start/busy port, and every result is checked
// against an interpolation model kept in the bench. Depends on ltr_pkg and the RTL.

module tb_linear_trace_resampler_unit;
  import ltr_pkg::*;

  localparam int Depth = 4096;

  class resampler_scoreboard;
    logic signed [31:0] samples [Depth];
    bit                 loaded [Depth];
    logic signed [31:0] start_pos, step_pos, pad_val;
    logic [LenW-1:0]    trace_len;
    bit                 pad_en;
    logic signed [31:0] low_seen, high_seen;
    bit                 seen_any;
    ltr_out_t           pending_outputs[$];
    int                 errors;

    function new();
      start_pos = 0;
      step_pos  = 32'sd65536;
      trace_len = 1;
      pad_val   = 0;
      pad_en    = 0;
      low_seen  = 0;
      high_seen = 0;
      seen_any  = 0;
      errors    = 0;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_START:   start_pos = data;
        CFG_STEP:    step_pos  = data;
        CFG_LENGTH:  trace_len = data[LenW-1:0];
        CFG_PAD_VAL: pad_val   = data;
        CFG_PAD_EN:  pad_en    = data[0];
        default: ;
      endcase
    endfunction

    function ltr_out_t interp_sample(logic [11:0] n);
      longint   span, pos, ip, frac, s0, s1, value;
      ltr_out_t r;
      span = longint'(trace_len);
      if (span < 1) span = 1;
      if (span > Depth) span = Depth;
      pos = longint'(start_pos) + longint'(n) * longint'(step_pos);
      if (pos > 64'sd2147483647) pos = 64'sd2147483647;
      if (pos < -64'sd2147483648) pos = -64'sd2147483648;
      ip   = pos >>> 16;
      frac = pos - ip * 65536;
      if (ip < 0) begin
        value = pad_en ? longint'(pad_val) : longint'(samples[0]);
      end else if (ip >= span - 1) begin
        value = samples[span - 1];
        if (pad_en && pos > (span - 1) * 65536) value = pad_val;
      end else begin
        s0    = samples[ip];
        s1    = samples[ip + 1];
        value = s0 + ((frac * (s1 - s0)) >>> 16);
      end
      r.out_value = value[31:0];
      if (!seen_any || r.out_value < low_seen) low_seen = r.out_value;
      if (!seen_any || r.out_value > high_seen) high_seen = r.out_value;
      seen_any = 1;
      r.running_min = low_seen;
      r.running_max = high_seen;
      return r;
    endfunction

    function void note_item(ltr_in_t it);
      if (it.kind == KIND_LOAD) begin
        samples[it.sample_index] = it.sample_value;
        loaded[it.sample_index]  = 1;
      end else begin
        pending_outputs.push_back(interp_sample(it.sample_index));
      end
    endfunction

    function void compare_field(string what, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(ltr_out_t got);
      ltr_out_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("out_value", want.out_value, got.out_value);
      compare_field("running_min", want.running_min, got.running_min);
      compare_field("running_max", want.running_max, got.running_max);
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ltr_in_t             item_i = '0;
  logic                result_valid_o;
  ltr_out_t            result_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  resampler_scoreboard sb;
  int unsigned         span_len = 1;
  int unsigned         sent = 0;
  bit                  quiet = 0;

  linear_trace_resampler_unit #(
    .TRACE_DEPTH(Depth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (result_valid_o) sb.check_result(result_o);
    end
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // wait for the sender side to have nothing in flight
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic drain();
    settle();
    repeat (12) @(posedge clk_i);
  endtask

  task automatic pause_after();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      settle();
    end else if (!quiet && r >= 60) begin
      start <= 1'b0;
      if (r < 94) repeat ($urandom_range(1, 3)) @(posedge clk_i);
      else repeat ($urandom_range(8, 40)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic kind, logic [11:0] idx, logic [31:0] val);
    ltr_in_t it;
    it.kind         = kind;
    it.sample_index = idx;
    it.sample_value = val;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sent++;
    pause_after();
  endtask

  // only called while idle
  task automatic program_regs(logic [31:0] st, logic [31:0] sp, logic [LenW-1:0] len,
                              logic [31:0] pv, bit pe);
    logic [CfgDataW-1:0] vals [5];
    logic [CfgIdxW-1:0]  idxs [5];
    vals = '{st, sp, 32'(len), pv, 32'(pe)};
    idxs = '{CFG_START, CFG_STEP, CFG_LENGTH, CFG_PAD_VAL, CFG_PAD_EN};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    span_len = (len == 0) ? 1 : (len > Depth) ? Depth : len;
  endtask

  // every entry from lo up that a query can read must hold a written sample
  task automatic fill_span(int unsigned lo);
    for (int unsigned i = lo; i < span_len; i++) begin
      if (!sb.loaded[i]) send_item(KIND_LOAD, 12'(i), rand_sample());
    end
  endtask

  task automatic run_phase(int phase, int unsigned count);
    longint          reach, st, sp, eff;
    logic [LenW-1:0] len;
    bit              wide, big;
    int unsigned     r;
    case ($urandom_range(0, 19))
      0: len = 0;
      1: len = Depth;
      2: len = $urandom_range(Depth + 1, 8191);
      3: len = $urandom_range(1, Depth);
      4: len = 1;
      5: len = 2;
      default: len = $urandom_range(2, 64);
    endcase
    if (phase == 1) len = 13'h1fff;
    if (phase == 4) len = Depth;
    eff  = longint'((len == 0) ? 1 : (len > Depth) ? Depth : len);
    // long traces: queries stay in a window near the top end
    big  = (eff > 64);
    wide = !big && ($urandom_range(0, 3) == 0);
    if (wide) begin
      st = rand_word();
      sp = rand_word();
    end else if (big) begin
      st = (eff - 40) * 65536 + longint'($urandom_range(0, 48 * 65536));
      sp = $urandom_range(0, 32768);
      if ($urandom_range(0, 2) == 0) sp = -sp;
    end else begin
      reach = eff * 65536;
      st = longint'($urandom_range(0, 32'(reach + 4 * 65536))) - 2 * 65536;
      sp = $urandom_range(0, 32'(reach / 24 + 65536));
      if ($urandom_range(0, 2) == 0) sp = -sp;
    end
    program_regs(32'(st), 32'(sp), len, rand_word(), 1'($urandom_range(0, 1)));
    fill_span((big && eff > 80) ? 32'(eff - 80) : 0);
    quiet = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_item(KIND_LOAD, 12'($urandom_range(0, span_len - 1)), rand_sample());
      end else if (r < 20) begin
        send_item(KIND_LOAD, 12'($urandom_range(0, 4095)), rand_sample());
      end else if (!big && (wide || r >= 90)) begin
        send_item(KIND_QUERY, 12'($urandom_range(0, 4095)), $urandom);
      end else begin
        send_item(KIND_QUERY, 12'($urandom_range(0, 63)), $urandom);
      end
    end
    quiet = 0;
  endtask

  initial begin
    int unsigned count;
    int          phase;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one sample, unit step
    send_item(KIND_LOAD, 12'd0, 32'h7fff_ffff);
    send_item(KIND_QUERY, 12'd0, 32'h0);
    send_item(KIND_QUERY, 12'hfff, 32'hffff_ffff);
    send_item(KIND_LOAD, 12'hfff, 32'h1234_5678);
    send_item(KIND_LOAD, 12'd0, 32'h8000_0000);
    send_item(KIND_QUERY, 12'd0, 32'h0);
    drain();

    // half-sample steps from -1.5 across four extreme samples, padded
    program_regs(32'hfffe_8000, 32'h0000_8000, 13'd4, 32'h8000_0000, 1'b1);
    send_item(KIND_LOAD, 12'd0, 32'h8000_0000);
    send_item(KIND_LOAD, 12'd1, 32'h7fff_ffff);
    send_item(KIND_LOAD, 12'd2, 32'h0000_0000);
    send_item(KIND_LOAD, 12'd3, 32'hffff_ffff);
    for (int n = 0; n <= 10; n++) send_item(KIND_QUERY, 12'(n), 32'h0);
    drain();

    program_regs(32'hfffe_8000, 32'h0000_8000, 13'd4, 32'h7fff_ffff, 1'b0);
    send_item(KIND_QUERY, 12'd0, 32'h0);
    send_item(KIND_QUERY, 12'd10, 32'h0);
    drain();

    // zero length, positive saturation
    program_regs(32'h7fff_ffff, 32'h7fff_ffff, 13'd0, 32'h1234_5678, 1'b1);
    send_item(KIND_QUERY, 12'hfff, 32'h0);
    send_item(KIND_QUERY, 12'd0, 32'h0);
    drain();

    // negative saturation
    program_regs(32'h8000_0000, 32'h8000_0000, 13'd2, 32'h0, 1'b1);
    send_item(KIND_QUERY, 12'hfff, 32'h0);
    send_item(KIND_QUERY, 12'd1, 32'h0);
    drain();

    phase = 0;
    while (sent < 1800) begin
      count = $urandom_range(30, 90);
      run_phase(phase, count);
      drain();
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
